@@ hdl/three_wire_serial_master_macros.svh @@
// Assertion macros used by the serial master RTL.
`ifndef THREE_WIRE_SERIAL_MASTER_MACROS_SVH
`define THREE_WIRE_SERIAL_MASTER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TWS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("serial master check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define TWS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("serial master check failed");

`endif

@@ hdl/tws_pkg.sv @@
package tws_pkg;

  // Phase codes of the bus sequencer.
  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_CE_LOW = 4'd1;
  localparam logic [3:0] PH_SETUP  = 4'd2;
  localparam logic [3:0] PH_CMD_LO = 4'd3;
  localparam logic [3:0] PH_CMD_HI = 4'd4;
  localparam logic [3:0] PH_CMD_TL = 4'd5;
  localparam logic [3:0] PH_DAT_LO = 4'd6;
  localparam logic [3:0] PH_DAT_HI = 4'd7;
  localparam logic [3:0] PH_DAT_TL = 4'd8;
  localparam logic [3:0] PH_RD_SMP = 4'd9;
  localparam logic [3:0] PH_RD_HI  = 4'd10;
  localparam logic [3:0] PH_RD_LO  = 4'd11;
  localparam logic [3:0] PH_END    = 4'd12;

  // Tick commands.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Configuration register indexes.
  localparam logic REG_UNIT_TICKS  = 1'b0;
  localparam logic REG_SETUP_UNITS = 1'b1;

  localparam int WAIT_W = 20;

  typedef struct packed {
    logic [3:0]        phase;
    logic [2:0]        bit_index;
    logic [7:0]        command_shift;
    logic [7:0]        data_shift;
    logic [7:0]        read_shift;
    logic              is_read;
    logic [WAIT_W-1:0] wait_count;
  } tws_state_t;

  typedef struct packed {
    logic       ce_pin;
    logic       sclk_pin;
    logic       io_out;
    logic       io_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       rejected;
  } tws_result_t;

endpackage

@@ hdl/tws_step.sv @@
module tws_step (
  input  tws_pkg::tws_state_t  state,
  input  logic [15:0]          unit_ticks,
  input  logic [3:0]           setup_units,
  input  logic [1:0]           cmd,
  input  logic [7:0]           command_byte,
  input  logic [7:0]           write_data,
  input  logic                 io_in,
  output tws_pkg::tws_state_t  state_next,
  output tws_pkg::tws_result_t result
);
  import tws_pkg::*;

  logic              start;
  tws_state_t        cur;
  logic [15:0]       unit_len;
  logic [3:0]        setup_eff;
  logic [WAIT_W-1:0] setup_len;
  logic [WAIT_W-1:0] phase_len;
  logic [WAIT_W:0]   wait_inc;
  logic              phase_last;
  logic              cb;
  logic              db;
  logic              ce;
  logic              clk_lvl;
  logic              io;
  logic              drv;
  logic              done;

  assign start = (cmd == CMD_READ) || (cmd == CMD_WRITE);

  // Zero register values count as one.
  assign unit_len  = (unit_ticks == 16'd0) ? 16'd1 : unit_ticks;
  assign setup_eff = (setup_units == 4'd0) ? 4'd1 : setup_units;
  assign setup_len = WAIT_W'(unit_len) * WAIT_W'(setup_eff);

  // Load a new transaction on an idle tick; the first phase shows at once.
  always_comb begin
    cur = state;
    if (state.phase == PH_IDLE && start) begin
      cur.command_shift = command_byte;
      cur.data_shift    = write_data;
      cur.is_read       = (cmd == CMD_READ);
      cur.bit_index     = 3'd0;
      cur.wait_count    = '0;
      cur.phase         = PH_CE_LOW;
    end
  end

  assign cb = cur.command_shift[cur.bit_index];
  assign db = cur.data_shift[cur.bit_index];

  // Pin levels for the current phase.
  always_comb begin
    ce      = 1'b1;
    clk_lvl = 1'b0;
    io      = 1'b0;
    drv     = 1'b1;
    unique case (cur.phase)
      PH_CMD_LO: io = cb;
      PH_CMD_HI: begin
        clk_lvl = 1'b1;
        io      = cb;
      end
      PH_CMD_TL: begin
        if (!cur.is_read) begin
          io = cb;
        end else if (cur.bit_index == 3'd7) begin
          drv = 1'b0;
        end
      end
      PH_DAT_LO: io = db;
      PH_DAT_HI: begin
        clk_lvl = 1'b1;
        io      = db;
      end
      PH_DAT_TL: io = db;
      PH_RD_SMP: drv = 1'b0;
      PH_RD_HI: begin
        clk_lvl = 1'b1;
        drv     = 1'b0;
      end
      PH_RD_LO: drv = 1'b0;
      PH_SETUP: ;
      default:  ce = 1'b0;
    endcase
  end

  // Length of the current phase in ticks.
  always_comb begin
    unique case (cur.phase)
      PH_CE_LOW: phase_len = WAIT_W'(1);
      PH_SETUP:  phase_len = setup_len;
      PH_END:    phase_len = cur.is_read ? WAIT_W'(1) : setup_len;
      default:   phase_len = WAIT_W'(unit_len);
    endcase
  end

  assign wait_inc   = {1'b0, cur.wait_count} + (WAIT_W+1)'(1);
  assign phase_last = wait_inc >= {1'b0, phase_len};

  // Sampling, tick counting and phase sequencing.
  always_comb begin
    state_next = cur;
    done       = 1'b0;
    if (cur.phase != PH_IDLE) begin
      if (cur.phase == PH_RD_SMP && cur.wait_count == '0) begin
        state_next.read_shift[cur.bit_index] = io_in;
      end
      if (phase_last) begin
        state_next.wait_count = '0;
        unique case (cur.phase)
          PH_CE_LOW: state_next.phase = PH_SETUP;
          PH_SETUP: begin
            state_next.phase     = PH_CMD_LO;
            state_next.bit_index = 3'd0;
          end
          PH_CMD_LO: state_next.phase = PH_CMD_HI;
          PH_CMD_HI: state_next.phase = PH_CMD_TL;
          PH_CMD_TL: begin
            if (cur.bit_index != 3'd7) begin
              state_next.phase     = PH_CMD_LO;
              state_next.bit_index = cur.bit_index + 3'd1;
            end else begin
              state_next.phase     = cur.is_read ? PH_RD_SMP : PH_DAT_LO;
              state_next.bit_index = 3'd0;
            end
          end
          PH_DAT_LO: state_next.phase = PH_DAT_HI;
          PH_DAT_HI: state_next.phase = PH_DAT_TL;
          PH_DAT_TL: begin
            if (cur.bit_index != 3'd7) begin
              state_next.phase     = PH_DAT_LO;
              state_next.bit_index = cur.bit_index + 3'd1;
            end else begin
              state_next.phase = PH_END;
            end
          end
          PH_RD_SMP: state_next.phase = PH_RD_HI;
          PH_RD_HI:  state_next.phase = PH_RD_LO;
          PH_RD_LO: begin
            if (cur.bit_index != 3'd7) begin
              state_next.phase     = PH_RD_SMP;
              state_next.bit_index = cur.bit_index + 3'd1;
            end else begin
              state_next.phase = PH_END;
            end
          end
          PH_END: begin
            state_next.phase = PH_IDLE;
            done             = 1'b1;
          end
          default: state_next.phase = PH_IDLE;
        endcase
      end else begin
        state_next.wait_count = wait_inc[WAIT_W-1:0];
      end
    end
  end

  // Assemble the result of this tick.
  always_comb begin
    result.ce_pin    = ce;
    result.sclk_pin  = clk_lvl;
    result.io_out    = io & drv;
    result.io_drive  = drv;
    result.busy_res  = (cur.phase != PH_IDLE);
    result.done_res  = done;
    result.read_data = state_next.read_shift;
    result.rejected  = (state.phase != PH_IDLE) && start;
  end

endmodule

@@ hdl/three_wire_serial_master.sv @@
// Three-wire serial bus master (CE, SCLK, bidirectional IO), driven one tick
// per input transaction. Every accepted tick produces exactly one result
// transaction carrying the pin levels, status flags and the read byte. A tick
// is accepted in every cycle while the result register is empty or being
// taken, so the sustained rate is one tick per clock; the result appears in the
// cycle after acceptance. The single-pass phase sequencer updates its state
// and fills the result register in the same clock edge. Bus timing is counted
// in ticks, not clocks: a delay unit is unit_ticks ticks and the setup delay
// is setup_units units. The configuration registers are written through
// cfg_we, cfg_index and cfg_data and take effect on the next tick.
`include "three_wire_serial_master_macros.svh"

module three_wire_serial_master (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  command_byte,
  input  logic [7:0]  write_data,
  input  logic        io_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ce_pin,
  output logic        sclk_pin,
  output logic        io_out,
  output logic        io_drive,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  read_data,
  output logic        rejected
);
  import tws_pkg::*;

  logic [15:0] unit_ticks;
  logic [3:0]  setup_units;
  tws_state_t  state;
  tws_state_t  state_next;
  tws_result_t step_result;
  tws_result_t result;
  logic        in_take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks  <= 16'd1;
      setup_units <= 4'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_UNIT_TICKS:  unit_ticks  <= cfg_data;
        REG_SETUP_UNITS: setup_units <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  tws_step u_step (
    .state        (state),
    .unit_ticks   (unit_ticks),
    .setup_units  (setup_units),
    .cmd          (cmd),
    .command_byte (command_byte),
    .write_data   (write_data),
    .io_in        (io_in),
    .state_next   (state_next),
    .result       (step_result)
  );

  // A new tick is taken whenever the result register is free or draining.
  assign in_ready = !out_valid || out_ready;
  assign in_take  = in_valid && in_ready;

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_take) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      result <= step_result;
    end
  end

  assign ce_pin    = result.ce_pin;
  assign sclk_pin  = result.sclk_pin;
  assign io_out    = result.io_out;
  assign io_drive  = result.io_drive;
  assign busy_res  = result.busy_res;
  assign done_res  = result.done_res;
  assign read_data = result.read_data;
  assign rejected  = result.rejected;

  // A finishing tick is a busy tick with CE already dropped.
  `TWS_ASSERT_IMP(a_done_in_end, out_valid && done_res, busy_res && !ce_pin)
  // A released IO line is never reported as driven high.
  `TWS_ASSERT_IMP(a_released_low, out_valid && !io_drive, !io_out)
  // A start on an idle tick is taken and begins a transaction at once.
  `TWS_ASSERT_NXT(a_start_taken,
    in_take && state.phase == PH_IDLE && (cmd == CMD_READ || cmd == CMD_WRITE),
    out_valid && busy_res && !rejected && !ce_pin)
  // The sequencer never enters an unused phase code.
  `TWS_ASSERT_IMP(a_phase_range, 1'b1, state.phase <= PH_END)

endmodule

@@ tb/tb_three_wire_serial_master.sv @@
module tb_three_wire_serial_master;
  import tws_pkg::*;

  // Command value three carries no meaning and must behave as a plain tick.
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam int STALL_LIMIT = 5000;
  localparam int DIR_ROWS = 14;
  localparam int NUM_SETTINGS = 6;

  // Timing settings walked by the random part, extremes and zero values included.
  localparam logic [15:0] UNIT_SET [NUM_SETTINGS] =
    '{16'd1, 16'd2, 16'd0, 16'd1, 16'd3, 16'hFFFF};
  localparam logic [15:0] SETUP_SET [NUM_SETTINGS] =
    '{16'd4, 16'd1, 16'hFFF0, 16'd15, 16'd2, 16'd15};
  localparam int TICK_BUDGET [NUM_SETTINGS] = '{60, 40, 60, 40, 30, 15};

  // Results that can be read straight off the bus behaviour.
  localparam tws_result_t PINS_IDLE = '{ce_pin: 1'b0, sclk_pin: 1'b0, io_out: 1'b0,
    io_drive: 1'b1, busy_res: 1'b0, done_res: 1'b0, read_data: 8'h00, rejected: 1'b0};
  localparam tws_result_t PINS_CE_DROP = '{ce_pin: 1'b0, sclk_pin: 1'b0, io_out: 1'b0,
    io_drive: 1'b1, busy_res: 1'b1, done_res: 1'b0, read_data: 8'h00, rejected: 1'b0};
  localparam tws_result_t PINS_SETUP_REJECT = '{ce_pin: 1'b1, sclk_pin: 1'b0, io_out: 1'b0,
    io_drive: 1'b1, busy_res: 1'b1, done_res: 1'b0, read_data: 8'h00, rejected: 1'b1};

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] cbyte;
    logic [7:0] wbyte;
    logic       io;
  } tick_item_t;

  // How a directed row is reached: directly, once the bus is idle, or on the done tick.
  typedef enum logic [1:0] {FILL_NONE, FILL_TO_IDLE, FILL_TO_LAST} fill_t;

  typedef struct {
    fill_t       fill;
    logic [1:0]  cmd;
    logic [7:0]  cbyte;
    logic [7:0]  wbyte;
    logic        io;
    bit          typed;
    tws_result_t want;
  } dir_row_t;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{FILL_NONE,    CMD_TICK,  8'h00, 8'h00, 1'b0, 1'b1, PINS_IDLE},
    '{FILL_NONE,    CMD_SPARE, 8'hFF, 8'hFF, 1'b1, 1'b1, PINS_IDLE},
    '{FILL_NONE,    CMD_WRITE, 8'hFF, 8'h00, 1'b0, 1'b1, PINS_CE_DROP},
    '{FILL_NONE,    CMD_READ,  8'h00, 8'hFF, 1'b1, 1'b1, PINS_SETUP_REJECT},
    '{FILL_NONE,    CMD_WRITE, 8'hA5, 8'h5A, 1'b0, 1'b1, PINS_SETUP_REJECT},
    '{FILL_NONE,    CMD_SPARE, 8'h00, 8'h00, 1'b1, 1'b0, PINS_IDLE},
    '{FILL_TO_IDLE, CMD_READ,  8'h00, 8'h00, 1'b1, 1'b1, PINS_CE_DROP},
    '{FILL_NONE,    CMD_TICK,  8'hFF, 8'hFF, 1'b1, 1'b0, PINS_IDLE},
    '{FILL_TO_IDLE, CMD_READ,  8'hFF, 8'h00, 1'b0, 1'b0, PINS_IDLE},
    '{FILL_TO_IDLE, CMD_WRITE, 8'h00, 8'hFF, 1'b1, 1'b0, PINS_IDLE},
    '{FILL_TO_LAST, CMD_READ,  8'h3C, 8'h00, 1'b0, 1'b0, PINS_IDLE},
    '{FILL_TO_IDLE, CMD_WRITE, 8'h96, 8'h69, 1'b1, 1'b0, PINS_IDLE},
    '{FILL_TO_LAST, CMD_WRITE, 8'h00, 8'h00, 1'b1, 1'b0, PINS_IDLE},
    '{FILL_TO_IDLE, CMD_READ,  8'h80, 8'h01, 1'b0, 1'b0, PINS_IDLE}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_UNIT_TICKS;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = CMD_TICK;
  logic [7:0]  command_byte = '0;
  logic [7:0]  write_data = '0;
  logic        io_in = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        ce_pin;
  logic        sclk_pin;
  logic        io_out;
  logic        io_drive;
  logic        busy_res;
  logic        done_res;
  logic [7:0]  read_data;
  logic        rejected;

  // Own copy of the sequencer state and of the timing registers.
  logic [3:0]  bus_phase = PH_IDLE;
  logic [2:0]  bus_bit = '0;
  logic [7:0]  cmd_sr = '0;
  logic [7:0]  dat_sr = '0;
  logic [7:0]  rd_sr = '0;
  logic        rd_mode = 1'b0;
  logic [19:0] tick_cnt = '0;
  logic [15:0] cfg_unit = 16'd1;
  logic [3:0]  cfg_setup = 4'd4;

  tws_result_t bus_forecast[$];
  int          mismatches = 0;
  int          stall_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  three_wire_serial_master i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .command_byte(command_byte),
    .write_data  (write_data),
    .io_in       (io_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ce_pin      (ce_pin),
    .sclk_pin    (sclk_pin),
    .io_out      (io_out),
    .io_drive    (io_drive),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .read_data   (read_data),
    .rejected    (rejected)
  );

  always #5 clk = ~clk;

  // Length of the current pin phase in ticks; zero registers count as one.
  function automatic int unsigned phase_ticks();
    int unsigned unit_len;
    int unsigned setup_len;
    unit_len = (cfg_unit == 16'd0) ? 1 : cfg_unit;
    setup_len = ((cfg_setup == 4'd0) ? 1 : cfg_setup) * unit_len;
    case (bus_phase)
      PH_CE_LOW: return 1;
      PH_SETUP:  return setup_len;
      PH_END:    return rd_mode ? 1 : setup_len;
      default:   return unit_len;
    endcase
  endfunction

  // Moves to the following pin phase; returns 1 when the transfer has finished.
  function automatic bit advance_phase();
    case (bus_phase)
      PH_CE_LOW: bus_phase = PH_SETUP;
      PH_SETUP: begin
        bus_phase = PH_CMD_LO;
        bus_bit = '0;
      end
      PH_CMD_LO: bus_phase = PH_CMD_HI;
      PH_CMD_HI: bus_phase = PH_CMD_TL;
      PH_CMD_TL: begin
        if (bus_bit != 3'd7) begin
          bus_phase = PH_CMD_LO;
          bus_bit = bus_bit + 3'd1;
        end else begin
          bus_phase = rd_mode ? PH_RD_SMP : PH_DAT_LO;
          bus_bit = '0;
        end
      end
      PH_DAT_LO: bus_phase = PH_DAT_HI;
      PH_DAT_HI: bus_phase = PH_DAT_TL;
      PH_DAT_TL: begin
        if (bus_bit != 3'd7) begin
          bus_phase = PH_DAT_LO;
          bus_bit = bus_bit + 3'd1;
        end else begin
          bus_phase = PH_END;
        end
      end
      PH_RD_SMP: bus_phase = PH_RD_HI;
      PH_RD_HI:  bus_phase = PH_RD_LO;
      PH_RD_LO: begin
        if (bus_bit != 3'd7) begin
          bus_phase = PH_RD_SMP;
          bus_bit = bus_bit + 3'd1;
        end else begin
          bus_phase = PH_END;
        end
      end
      PH_END: begin
        bus_phase = PH_IDLE;
        return 1'b1;
      end
      default: bus_phase = PH_IDLE;
    endcase
    return 1'b0;
  endfunction

  // Works out the pins and status for one tick and advances the sequencer.
  function automatic tws_result_t step_bus(input tick_item_t t);
    tws_result_t r;
    logic        start;
    logic        cbit;
    logic        dbit;
    r = '0;
    start = (t.cmd == CMD_READ) || (t.cmd == CMD_WRITE);
    if (bus_phase == PH_IDLE) begin
      if (start) begin
        cmd_sr = t.cbyte;
        dat_sr = t.wbyte;
        rd_mode = (t.cmd == CMD_READ);
        bus_bit = '0;
        tick_cnt = '0;
        bus_phase = PH_CE_LOW;
      end
    end else if (start) begin
      r.rejected = 1'b1;
    end

    cbit = cmd_sr[bus_bit];
    dbit = dat_sr[bus_bit];
    r.ce_pin = 1'b1;
    r.io_drive = 1'b1;
    case (bus_phase)
      PH_CMD_LO: r.io_out = cbit;
      PH_CMD_HI: begin
        r.sclk_pin = 1'b1;
        r.io_out = cbit;
      end
      PH_CMD_TL: begin
        if (!rd_mode) r.io_out = cbit;
        else if (bus_bit == 3'd7) r.io_drive = 1'b0;
      end
      PH_DAT_LO, PH_DAT_TL: r.io_out = dbit;
      PH_DAT_HI: begin
        r.sclk_pin = 1'b1;
        r.io_out = dbit;
      end
      PH_RD_SMP, PH_RD_LO: r.io_drive = 1'b0;
      PH_RD_HI: begin
        r.sclk_pin = 1'b1;
        r.io_drive = 1'b0;
      end
      PH_SETUP: ;
      default: r.ce_pin = 1'b0;
    endcase

    if (bus_phase != PH_IDLE) begin
      r.busy_res = 1'b1;
      // The read bit is taken on the first tick of its sampling phase only.
      if (bus_phase == PH_RD_SMP && tick_cnt == '0) rd_sr[bus_bit] = t.io;
      if (tick_cnt + 1 >= phase_ticks()) begin
        tick_cnt = '0;
        r.done_res = advance_phase();
      end else begin
        tick_cnt = tick_cnt + 20'd1;
      end
    end
    r.read_data = rd_sr;
    return r;
  endfunction

  function automatic bit last_tick_next();
    return bus_phase == PH_END && tick_cnt + 1 >= phase_ticks();
  endfunction

  function automatic tick_item_t filler_tick();
    tick_item_t t;
    t.cmd = CMD_TICK;
    t.cbyte = 8'($urandom);
    t.wbyte = 8'($urandom);
    t.io = 1'($urandom_range(1));
    return t;
  endfunction

  // Mostly complete transfers with random content; some stray starts and spare commands.
  function automatic tick_item_t random_tick();
    tick_item_t t;
    int         pick;
    t = filler_tick();
    pick = $urandom_range(99);
    if (bus_phase == PH_IDLE) begin
      if (pick < 70) t.cmd = $urandom_range(1) ? CMD_READ : CMD_WRITE;
      else if (pick < 90) t.cmd = CMD_TICK;
      else t.cmd = CMD_SPARE;
    end else if (last_tick_next()) begin
      if (pick < 50) t.cmd = $urandom_range(1) ? CMD_READ : CMD_WRITE;
    end else begin
      if (pick < 3) t.cmd = CMD_READ;
      else if (pick < 6) t.cmd = CMD_WRITE;
      else if (pick < 9) t.cmd = CMD_SPARE;
    end
    return t;
  endfunction

  // Presents one tick, waits for the transaction and records what must come back.
  task automatic send_tick(input tick_item_t t, input bit typed, input tws_result_t want);
    tws_result_t forecast;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    cmd = t.cmd;
    command_byte = t.cbyte;
    write_data = t.wbyte;
    io_in = t.io;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    forecast = step_bus(t);
    bus_forecast.push_back(typed ? want : forecast);
    @(negedge clk);
  endtask

  // Holds the sender back until every forecast result has been taken.
  task automatic drain();
    in_valid = 1'b0;
    while (bus_forecast.size() != 0) @(negedge clk);
  endtask

  task automatic load_timing(input logic [15:0] unit_word, input logic [15:0] setup_word);
    cfg_we = 1'b1;
    cfg_index = REG_UNIT_TICKS;
    cfg_data = unit_word;
    cfg_unit = unit_word;
    @(negedge clk);
    cfg_index = REG_SETUP_UNITS;
    cfg_data = setup_word;
    cfg_setup = setup_word[3:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Result side: random back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result transaction with the oldest forecast.
  always @(posedge clk) begin
    tws_result_t exp_pins;
    if (!rst && out_valid && out_ready) begin
      if (bus_forecast.size() == 0) begin
        $error("result transaction arrived with nothing forecast");
        mismatches++;
      end else begin
        exp_pins = bus_forecast.pop_front();
        check_field("ce_pin", exp_pins.ce_pin, ce_pin);
        check_field("sclk_pin", exp_pins.sclk_pin, sclk_pin);
        check_field("io_out", exp_pins.io_out, io_out);
        check_field("io_drive", exp_pins.io_drive, io_drive);
        check_field("busy_res", exp_pins.busy_res, busy_res);
        check_field("done_res", exp_pins.done_res, done_res);
        check_field("read_data", exp_pins.read_data, read_data);
        check_field("rejected", exp_pins.rejected, rejected);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("tb_three_wire_serial_master: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    dir_row_t   row;
    tick_item_t t;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Directed part under the reset timing, with the sender and receiver idling.
    send_idle_pct = 10;
    recv_idle_pct = 68;
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_table[i];
      if (row.fill == FILL_TO_IDLE) begin
        while (bus_phase != PH_IDLE) send_tick(filler_tick(), 1'b0, PINS_IDLE);
      end else if (row.fill == FILL_TO_LAST) begin
        while (!last_tick_next()) send_tick(filler_tick(), 1'b0, PINS_IDLE);
      end
      t.cmd = row.cmd;
      t.cbyte = row.cbyte;
      t.wbyte = row.wbyte;
      t.io = row.io;
      send_tick(t, row.typed, row.want);
    end

    // Random part: three idling patterns, each walking all timing settings.
    // A transfer may still be running when the timing changes.
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 10 : (mode == 1) ? 68 : 0;
      recv_idle_pct = (mode == 0) ? 68 : (mode == 1) ? 10 : 0;
      for (int s = 0; s < NUM_SETTINGS; s++) begin
        drain();
        load_timing(UNIT_SET[s], SETUP_SET[s]);
        for (int n = 0; n < TICK_BUDGET[s]; n++) send_tick(random_tick(), 1'b0, PINS_IDLE);
      end
    end

    drain();
    repeat (5) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_three_wire_serial_master: PASS");
    end else begin
      $display("tb_three_wire_serial_master: FAIL");
    end
    $finish;
  end

endmodule
